// ----- hdl/ers_pkg.sv -----
// ----------------------------------------------------------------------------
// ers_pkg: shared definitions for the elevator request scheduler
// Entry layout, cell control, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ers_pkg;

  // default sizing
  localparam int NumFloors  = 9;
  localparam int QueueDepth = 16;

  // one waiting ride request
  typedef struct packed {
    logic [3:0] origin;
    logic [3:0] dest;
  } entry_t;

  // control broadcast to every queue cell
  typedef struct packed {
    logic shift;     // whole queue moves one cell toward the head
    logic reinsert;  // head entry kept, goes back in behind the last one
    logic append;    // new request written at the first free cell
  } cell_ctrl_t;

  // result status codes
  typedef enum logic [2:0] {
    StatQueued  = 3'd0,
    StatFull    = 3'd1,
    StatBad     = 3'd2,
    StatIdle    = 3'd3,
    StatUp      = 3'd4,
    StatDown    = 3'd5,
    StatArrived = 3'd6
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StBoard,
    StFront,
    StMove
  } state_e;

endpackage

// ----- hdl/ers_cell.sv -----
// ----------------------------------------------------------------------------
// ers_cell: one slot of the waiting request queue
// Takes its neighbour's entry on a shift, or a new entry when it is the slot
// at the end of the queue.
// ----------------------------------------------------------------------------
module ers_cell #(
  parameter int INDEX  = 0,
  parameter int FILL_W = 5
) (
  input  logic                     clk_i,
  input  ers_pkg::cell_ctrl_t      ctrl_i,
  input  logic [FILL_W-1:0]        fill_i,
  input  ers_pkg::entry_t          next_entry_i,
  input  ers_pkg::entry_t          new_entry_i,
  output ers_pkg::entry_t          entry_o
);

  localparam logic [FILL_W-1:0] SlotHere = FILL_W'(INDEX);
  localparam logic [FILL_W-1:0] SlotNext = FILL_W'(INDEX + 1);

  ers_pkg::entry_t entry_q, entry_d;

  // slot update: shift, reinsert at the tail or append
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      if (ctrl_i.reinsert && (fill_i == SlotNext)) begin
        entry_d = new_entry_i;
      end else begin
        entry_d = next_entry_i;
      end
    end else if (ctrl_i.append && (fill_i == SlotHere)) begin
      entry_d = new_entry_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/elevator_request_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// elevator_request_scheduler_unit: elevator car controller
// Queues ride requests in a row of cells, boards riders on each tick and
// picks the next stop LOOK style, moving the car at most one floor per tick.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  command   in         start && !busy         operation_i, origin_floor_i, dest_floor_i
//  result    out        valid_o, one cycle     status_o, car_position_o, heading_is_up_o,
//                                              chosen_stop_o, waiting_count_o, work_left_o
//
//  a request's result shows the cycle after the transfer
//  a tick runs a boarding pass that rotates the queue through its head cell
//  one entry a cycle, then a step for the front request and a step for stop
//  choice and car movement
//  busy is high while a tick is in progress; the receiver cannot stall results
//  reset (rst_ni low) puts the car on floor 1 heading up with an empty queue
//
module elevator_request_scheduler_unit #(
  parameter int NUM_FLOORS  = ers_pkg::NumFloors,
  parameter int QUEUE_DEPTH = ers_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       operation_i,
  input  logic [3:0] origin_floor_i,
  input  logic [3:0] dest_floor_i,
  output logic       valid_o,
  output logic [2:0] status_o,
  output logic [3:0] car_position_o,
  output logic       heading_is_up_o,
  output logic [3:0] chosen_stop_o,
  output logic [4:0] waiting_count_o,
  output logic       work_left_o
);

  localparam int          FillW    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0]  TopFloor = 4'(NUM_FLOORS);
  localparam logic [FillW-1:0] FullCount = FillW'(QUEUE_DEPTH);

  // state
  ers_pkg::state_e        state_q, state_d;
  logic [3:0]             car_q, car_d;
  logic                   heading_q, heading_d;
  logic [NUM_FLOORS-1:0]  stops_q, stops_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic [FillW-1:0]       left_q, left_d;
  logic                   res_valid_q, res_valid_d;
  ers_pkg::status_e       res_status_q, res_status_d;
  logic [3:0]             res_chosen_q, res_chosen_d;

  // queue
  ers_pkg::cell_ctrl_t    ctrl;
  ers_pkg::entry_t        new_entry;
  ers_pkg::entry_t        cell_entry [QUEUE_DEPTH];
  ers_pkg::entry_t        head;

  logic                   accept;
  logic                   bad_floors;
  logic [NUM_FLOORS-1:0]  dest_bit;
  logic [NUM_FLOORS-1:0]  front_bit;
  logic [NUM_FLOORS-1:0]  car_bit;
  logic [3:0]             ahead_stop;
  logic [3:0]             behind_stop;
  logic [3:0]             pick;
  logic [31:0]            fill_ext;

  assign accept = start && !busy;
  assign head   = cell_entry[0];

  // row of queue cells, each fed by its neighbour toward the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ers_pkg::entry_t next_entry;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end
    ers_cell #(
      .INDEX  (i),
      .FILL_W (FillW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .fill_i       (fill_q),
      .next_entry_i (next_entry),
      .new_entry_i  (new_entry),
      .entry_o      (cell_entry[i])
    );
  end

  // floor decodes into stop set positions
  always_comb begin
    dest_bit  = '0;
    front_bit = '0;
    car_bit   = '0;
    for (int f = 1; f <= NUM_FLOORS; f++) begin
      dest_bit[f-1]  = (head.dest == 4'(f));
      front_bit[f-1] = (head.origin == 4'(f));
      car_bit[f-1]   = (car_q == 4'(f));
    end
  end

  // LOOK stop choice: floors in the heading first, nearest by file order
  always_comb begin
    ahead_stop  = '0;
    behind_stop = '0;
    if (heading_q) begin
      for (int f = NUM_FLOORS; f >= 1; f--) begin
        if (stops_q[f-1] && (4'(f) >= car_q)) ahead_stop = 4'(f);
        if (stops_q[f-1] && (4'(f) < car_q)) behind_stop = 4'(f);
      end
    end else begin
      for (int f = 1; f <= NUM_FLOORS; f++) begin
        if (stops_q[f-1] && (4'(f) < car_q)) ahead_stop = 4'(f);
        if (stops_q[f-1] && (4'(f) >= car_q)) behind_stop = 4'(f);
      end
    end
    pick = (ahead_stop != '0) ? ahead_stop : behind_stop;
  end

  assign bad_floors = (origin_floor_i < 4'd1) || (origin_floor_i > TopFloor) ||
                      (dest_floor_i < 4'd1) || (dest_floor_i > TopFloor) ||
                      (origin_floor_i == dest_floor_i);

  // sequencer: next state, queue control and result
  always_comb begin
    state_d      = state_q;
    car_d        = car_q;
    heading_d    = heading_q;
    stops_d      = stops_q;
    fill_d       = fill_q;
    left_d       = left_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_chosen_d = res_chosen_q;
    ctrl         = '0;
    new_entry    = '{origin: origin_floor_i, dest: dest_floor_i};

    unique case (state_q)
      ers_pkg::StIdle: begin
        if (accept) begin
          if (!operation_i) begin
            res_valid_d  = 1'b1;
            res_chosen_d = '0;
            if (bad_floors) begin
              res_status_d = ers_pkg::StatBad;
            end else if (fill_q == FullCount) begin
              res_status_d = ers_pkg::StatFull;
            end else begin
              ctrl.append  = 1'b1;
              fill_d       = fill_q + FillW'(1);
              res_status_d = ers_pkg::StatQueued;
            end
          end else begin
            left_d  = fill_q;
            state_d = (fill_q != '0) ? ers_pkg::StBoard : ers_pkg::StFront;
          end
        end
      end
      ers_pkg::StBoard: begin
        // head leaves; boarded riders add their stop, others go to the tail
        ctrl.shift = 1'b1;
        new_entry  = head;
        if (head.origin == car_q) begin
          stops_d = stops_q | dest_bit;
          fill_d  = fill_q - FillW'(1);
        end else begin
          ctrl.reinsert = 1'b1;
        end
        left_d = left_q - FillW'(1);
        if (left_q == FillW'(1)) begin
          state_d = ers_pkg::StFront;
        end
      end
      ers_pkg::StFront: begin
        // with no stop pending, fetch the oldest waiting rider
        if ((stops_q == '0) && (fill_q != '0)) begin
          stops_d = front_bit;
        end
        state_d = ers_pkg::StMove;
      end
      ers_pkg::StMove: begin
        res_valid_d  = 1'b1;
        res_chosen_d = pick;
        if (pick == '0) begin
          res_status_d = ers_pkg::StatIdle;
        end else if (pick > car_q) begin
          car_d        = car_q + 4'd1;
          heading_d    = 1'b1;
          res_status_d = ers_pkg::StatUp;
        end else if (pick < car_q) begin
          car_d        = car_q - 4'd1;
          heading_d    = 1'b0;
          res_status_d = ers_pkg::StatDown;
        end else begin
          stops_d      = stops_q & ~car_bit;
          res_status_d = ers_pkg::StatArrived;
        end
        state_d = ers_pkg::StIdle;
      end
      default: begin
        state_d = ers_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ers_pkg::StIdle;
      car_q       <= 4'd1;
      heading_q   <= 1'b1;
      stops_q     <= '0;
      fill_q      <= '0;
      left_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      car_q       <= car_d;
      heading_q   <= heading_d;
      stops_q     <= stops_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_chosen_q <= res_chosen_d;
  end

  // outputs
  assign fill_ext        = 32'(fill_q);
  assign busy            = (state_q != ers_pkg::StIdle);
  assign valid_o         = res_valid_q;
  assign status_o        = res_status_q;
  assign car_position_o  = car_q;
  assign heading_is_up_o = heading_q;
  assign chosen_stop_o   = res_chosen_q;
  assign waiting_count_o = fill_ext[4:0];
  assign work_left_o     = (stops_q != '0) || (fill_q != '0);

  // checks
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCount)
    else $error("queue count beyond depth");

  a_board_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ers_pkg::StBoard) |-> ((left_q != '0) && (left_q <= fill_q)))
    else $error("boarding pass count out of step with queue count");

  a_arrive_here : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ers_pkg::StatArrived)) |-> (chosen_stop_o == car_position_o))
    else $error("arrival reported away from the chosen stop");

  a_move_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ers_pkg::StMove) && (pick > car_q)) |=>
      (heading_q && (car_q == $past(car_q) + 4'd1)))
    else $error("upward move did not advance the car by one floor");

endmodule

// ----- sim/tb_elevator_request_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_elevator_request_scheduler_unit: self-checking bench for the car scheduler
// Drives ride requests and ticks through the start/busy handshake, directed and in random
// bursts, predicts every result with its own model of the car, the stop set
// and the waiting queue, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb_elevator_request_scheduler_unit;

  // operation codes on operation_i
  localparam logic OpRequest = 1'b0;
  localparam logic OpTick    = 1'b1;

  localparam int RandomItems = 1400;
  localparam int SettleCycles = 30;

  // one predicted result
  typedef struct {
    ers_pkg::status_e status;
    logic [3:0] position;
    logic       up;
    logic [3:0] stop;
    logic [4:0] waiting;
    logic       work;
  } car_outcome_t;

  // predicts the car's behaviour and holds the outcomes still to arrive
  class car_scoreboard;
    int              car;
    logic            going_up;
    logic [ers_pkg::NumFloors-1:0] stops;
    logic [3:0]      rider_origin[ers_pkg::QueueDepth];
    logic [3:0]      rider_dest[ers_pkg::QueueDepth];
    int              fill;
    car_outcome_t    outcome_q[$];
    int              errors;
    int              items;
    int              results;
    int              status_seen[8];

    function new();
      car      = 1;
      going_up = 1'b1;
      stops    = '0;
      fill     = 0;
      errors   = 0;
      items    = 0;
      results  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // LOOK choice: floors ahead in the heading first, nearest first
    function int next_stop();
      int f;
      if (stops == '0) return 0;
      if (going_up) begin
        for (f = car; f <= ers_pkg::NumFloors; f++) if (stops[f-1]) return f;
        for (f = 1; f < car; f++) if (stops[f-1]) return f;
      end else begin
        for (f = car - 1; f >= 1; f--) if (stops[f-1]) return f;
        for (f = ers_pkg::NumFloors; f >= car; f--) if (stops[f-1]) return f;
      end
      return 0;
    endfunction

    // note an accepted transfer and work out the result it causes
    function void log_command(logic op, logic [3:0] org, logic [3:0] dst);
      car_outcome_t o;
      int r;
      int kept;
      int target;
      o.stop = '0;
      if (op == OpRequest) begin
        if (org < 1 || org > ers_pkg::NumFloors || dst < 1 || dst > ers_pkg::NumFloors ||
            org == dst) begin
          o.status = ers_pkg::StatBad;
        end else if (fill >= ers_pkg::QueueDepth) begin
          o.status = ers_pkg::StatFull;
        end else begin
          rider_origin[fill] = org;
          rider_dest[fill]   = dst;
          fill++;
          o.status = ers_pkg::StatQueued;
        end
      end else begin
        // board riders on this floor, compact the rest in order
        kept = 0;
        for (r = 0; r < fill; r++) begin
          if (rider_origin[r] == car) begin
            stops[rider_dest[r]-1] = 1'b1;
          end else begin
            rider_origin[kept] = rider_origin[r];
            rider_dest[kept]   = rider_dest[r];
            kept++;
          end
        end
        fill = kept;
        // nothing pending: go and fetch the oldest rider
        if (stops == '0 && fill > 0) stops[rider_origin[0]-1] = 1'b1;
        target = next_stop();
        if (target == 0) begin
          o.status = ers_pkg::StatIdle;
        end else if (target > car) begin
          car++;
          going_up = 1'b1;
          o.status = ers_pkg::StatUp;
        end else if (target < car) begin
          car--;
          going_up = 1'b0;
          o.status = ers_pkg::StatDown;
        end else begin
          stops[target-1] = 1'b0;
          o.status = ers_pkg::StatArrived;
        end
        o.stop = 4'(target);
      end
      o.position = 4'(car);
      o.up       = going_up;
      o.waiting  = 5'(fill);
      o.work     = (stops != '0) || (fill != 0);
      outcome_q.push_back(o);
      items++;
      status_seen[o.status]++;
    endfunction

    task report(string what);
      errors++;
      $display("ERROR: %s", what);
    endtask

    // compare one strobed result with the oldest outcome
    task check_result(logic [2:0] status, logic [3:0] position, logic up,
                      logic [3:0] stop, logic [4:0] waiting, logic work);
      car_outcome_t o;
      results++;
      if (outcome_q.size() == 0) begin
        report($sformatf("result %0d arrived with no transfer outstanding", results));
      end else begin
        o = outcome_q.pop_front();
        if (status !== o.status || position !== o.position || up !== o.up ||
            stop !== o.stop || waiting !== o.waiting || work !== o.work) begin
          report($sformatf({"result %0d: got st=%0d pos=%0d up=%0b stop=%0d wait=%0d",
                            " work=%0b, want st=%0d pos=%0d up=%0b stop=%0d wait=%0d",
                            " work=%0b"},
                           results, status, position, up, stop, waiting, work,
                           o.status, o.position, o.up, o.stop, o.waiting, o.work));
        end
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       operation_i = OpRequest;
  logic [3:0] origin_floor_i = '0;
  logic [3:0] dest_floor_i = '0;
  logic       valid_o;
  logic [2:0] status_o;
  logic [3:0] car_position_o;
  logic       heading_is_up_o;
  logic [3:0] chosen_stop_o;
  logic [4:0] waiting_count_o;
  logic       work_left_o;

  car_scoreboard sb = new();

  elevator_request_scheduler_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .origin_floor_i  (origin_floor_i),
    .dest_floor_i    (dest_floor_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .car_position_o  (car_position_o),
    .heading_is_up_o (heading_is_up_o),
    .chosen_stop_o   (chosen_stop_o),
    .waiting_count_o (waiting_count_o),
    .work_left_o     (work_left_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // results first, then the transfer taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_result(status_o, car_position_o, heading_is_up_o, chosen_stop_o,
                      waiting_count_o, work_left_o);
    end
    if (rst_ni && start && !busy) sb.log_command(operation_i, origin_floor_i, dest_floor_i);
  end

  // present one item and hold it until the transfer
  task send_item(logic op, logic [3:0] org, logic [3:0] dst);
    start          <= 1'b1;
    operation_i    <= op;
    origin_floor_i <= org;
    dest_floor_i   <= dst;
    do @(posedge clk_i); while (busy);
  endtask

  task hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // stop sending until every outstanding result is back
  task drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // mostly well-formed requests, some raw field values, ticks at the given share
  task random_item(int tick_pct);
    logic [3:0] org;
    logic [3:0] dst;
    if ($urandom_range(0, 99) < tick_pct) begin
      send_item(OpTick, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if ($urandom_range(0, 9) == 0) begin
      send_item(OpRequest, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else begin
      org = 4'($urandom_range(1, ers_pkg::NumFloors));
      dst = 4'($urandom_range(1, ers_pkg::NumFloors - 1));
      if (dst >= org) dst = dst + 4'd1;
      send_item(OpRequest, org, dst);
    end
  endtask

  // stimulus
  initial begin
    int sent;
    int burst;
    int tick_pct;
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, bad floors, fill the queue, one refused, two ticks
    send_item(OpTick, 4'd0, 4'd0);
    send_item(OpRequest, 4'd0, 4'd9);
    send_item(OpRequest, 4'd9, 4'd0);
    send_item(OpRequest, 4'd10, 4'd15);
    send_item(OpRequest, 4'd15, 4'd3);
    send_item(OpRequest, 4'd5, 4'd5);
    for (k = 0; k < ers_pkg::QueueDepth; k++) begin
      send_item(OpRequest, 4'((k % ers_pkg::NumFloors) + 1),
                (k % ers_pkg::NumFloors == 8) ? 4'd1 : 4'd9);
    end
    send_item(OpRequest, 4'd2, 4'd8);
    send_item(OpTick, 4'd15, 4'd15);
    send_item(OpTick, 4'd0, 4'd0);
    drain();

    // random bursts: request-heavy, mixed and tick-heavy phases
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0:       tick_pct = 15;
        1:       tick_pct = 50;
        default: tick_pct = 85;
      endcase
      for (k = 0; k < burst; k++) begin
        random_item(tick_pct);
        sent++;
      end
      case ($urandom_range(0, 15))
        0:             drain();
        1, 2, 3:       hold_off($urandom_range(4, 25));
        4, 5, 6, 7, 8: hold_off($urandom_range(1, 3));
        default:       ;
      endcase
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d items: %0d queued, %0d refused full, %0d bad floors",
             sb.items, sb.status_seen[ers_pkg::StatQueued], sb.status_seen[ers_pkg::StatFull],
             sb.status_seen[ers_pkg::StatBad]);
    $display("ticks: %0d idle, %0d up, %0d down, %0d arrivals; %0d mismatches",
             sb.status_seen[ers_pkg::StatIdle], sb.status_seen[ers_pkg::StatUp],
             sb.status_seen[ers_pkg::StatDown], sb.status_seen[ers_pkg::StatArrived],
             sb.errors);
    if (sb.errors == 0) begin
      $display("elevator_request_scheduler_unit test passed");
    end else begin
      $display("elevator_request_scheduler_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("elevator_request_scheduler_unit test failed");
    $finish;
  end

endmodule
